>>> rtl/core/multi_channel_heartbeat_watchdog_core_defines.svh
// Assertion macros for the heartbeat watchdog core.
// Each macro expects clk_i and rst_ni in scope at the point of use.
`ifndef MULTI_CHANNEL_HEARTBEAT_WATCHDOG_CORE_DEFINES_SVH
`define MULTI_CHANNEL_HEARTBEAT_WATCHDOG_CORE_DEFINES_SVH

// same-cycle implication
`define MCHW_ASSERT_NOW(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |-> (cons)) \
    else $error(msg);

// next-cycle implication
`define MCHW_ASSERT_NEXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |=> (cons)) \
    else $error(msg);

`endif

>>> rtl/core/mchw_pkg.sv
// Shared types, constants and codes for the heartbeat watchdog core.
// No dependencies; used by every module in rtl/core.
package mchw_pkg;

  localparam int NumChannels   = 4;
  localparam int NumRegs       = 4;
  localparam int TimeoutFactor = 20;

  localparam int PeriodW  = 16;
  localparam int AgeW     = 21;
  localparam int IdW      = 22;
  localparam int ChW      = 3;
  localparam int MaskW    = 4;
  localparam int StatusW  = 3;
  localparam int RegIdxW  = $clog2(NumRegs);
  localparam int ChSelW   = (NumChannels > 1) ? $clog2(NumChannels) : 1;

  localparam logic [PeriodW-1:0] PeriodReset = PeriodW'(100);
  localparam logic [AgeW-1:0]    LimitReset  = AgeW'(100 * TimeoutFactor);
  localparam logic [AgeW-1:0]    AgeMax      = {AgeW{1'b1}};
  localparam logic [PeriodW-1:0] SampMax     = {PeriodW{1'b1}};

  typedef enum logic [StatusW-1:0] {
    StOk         = 3'd0,
    StBadChannel = 3'd1,
    StImperson   = 3'd2,
    StUnreg      = 3'd3,
    StTimeout    = 3'd4,
    StHalted     = 3'd5
  } status_e;

  typedef enum logic [1:0] {
    PhReg  = 2'd0,
    PhMon  = 2'd1,
    PhHalt = 2'd2
  } phase_e;

  typedef enum logic [3:0] {
    EvHalted,
    EvBadCh,
    EvImperson,
    EvBind,
    EvTickReg,
    EvWinPass,
    EvUnreg,
    EvTickMon,
    EvSampPass,
    EvTimeout
  } event_e;

  typedef struct packed {
    logic             mode;
    logic [ChW-1:0]   channel;
    logic [IdW-1:0]   sender_id;
  } in_item_t;

  typedef struct packed {
    status_e          status;
    logic [MaskW-1:0] kill_mask;
    logic [ChW-1:0]   failed_channel;
    logic             monitoring;
  } out_item_t;

  typedef struct packed {
    logic [NumRegs-1:0][PeriodW-1:0] period;
    logic [NumRegs-1:0][AgeW-1:0]    limit;
  } cfg_t;

endpackage

>>> rtl/core/mchw_cfg.sv
// Period registers and their per-channel age limits (period * timeout factor).
// Depends on mchw_pkg.
module mchw_cfg (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  input  logic                          cfg_valid_i,
  output logic                          cfg_ready_o,
  input  logic [mchw_pkg::RegIdxW-1:0]  cfg_index_i,
  input  logic [mchw_pkg::PeriodW-1:0]  cfg_wdata_i,
  output mchw_pkg::cfg_t                cfg_o
);

  logic [mchw_pkg::NumRegs-1:0][mchw_pkg::PeriodW-1:0] period_q;
  logic [mchw_pkg::NumRegs-1:0][mchw_pkg::AgeW-1:0]    limit_q;
  logic [mchw_pkg::AgeW-1:0]                           limit_d;

  assign cfg_ready_o = 1'b1;
  assign limit_d     = mchw_pkg::AgeW'(cfg_wdata_i) *
                       mchw_pkg::AgeW'(mchw_pkg::TimeoutFactor);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      for (int i = 0; i < mchw_pkg::NumRegs; i++) begin
        period_q[i] <= mchw_pkg::PeriodReset;
        limit_q[i]  <= mchw_pkg::LimitReset;
      end
    end else if (cfg_valid_i && cfg_ready_o) begin
      period_q[cfg_index_i] <= cfg_wdata_i;
      limit_q[cfg_index_i]  <= limit_d;
    end
  end

  assign cfg_o.period = period_q;
  assign cfg_o.limit  = limit_q;

endmodule

>>> rtl/core/mchw_eval.sv
// Watchdog state (phase, window, sample timer, owners, ages) and per-item evaluation.
// Depends on mchw_pkg; updates state only on the advance strobe from the top level.
module mchw_eval (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                advance_i,
  input  mchw_pkg::in_item_t  item_i,
  input  mchw_pkg::cfg_t      cfg_i,
  output mchw_pkg::out_item_t res_o
);

  localparam int NCh = mchw_pkg::NumChannels;

  mchw_pkg::phase_e                      phase_q, phase_d;
  mchw_pkg::event_e                      ev;
  logic [mchw_pkg::AgeW-1:0]             win_q, win_d, win_inc;
  logic [mchw_pkg::PeriodW-1:0]          samp_q, samp_d, samp_inc;
  logic [NCh-1:0][mchw_pkg::IdW-1:0]     owner_q, owner_d;
  logic [NCh-1:0][mchw_pkg::AgeW-1:0]    age_q, age_d, age_inc;

  logic [mchw_pkg::MaskW-1:0]            reg_mask;
  logic [mchw_pkg::AgeW-1:0]             max_lim;
  logic [mchw_pkg::PeriodW-1:0]          min_per;
  logic                                  unreg_any, late_any;
  logic [mchw_pkg::ChW-1:0]              unreg_idx, late_idx;
  logic                                  ch_ok, imperson;
  logic [mchw_pkg::ChSelW-1:0]           sel;
  logic [mchw_pkg::IdW-1:0]              sel_owner;

  assign win_inc  = (win_q == mchw_pkg::AgeMax) ? win_q : win_q + 1'b1;
  assign samp_inc = (samp_q == mchw_pkg::SampMax) ? samp_q : samp_q + 1'b1;
  assign ch_ok    = item_i.channel < mchw_pkg::ChW'(NCh);
  assign sel      = item_i.channel[mchw_pkg::ChSelW-1:0];
  assign sel_owner = ch_ok ? owner_q[sel] : '0;
  assign imperson = (sel_owner != '0) && (sel_owner != item_i.sender_id);

  always_comb begin
    reg_mask  = '0;
    max_lim   = '0;
    min_per   = cfg_i.period[0];
    unreg_any = 1'b0;
    late_any  = 1'b0;
    unreg_idx = '0;
    late_idx  = '0;
    for (int i = 0; i < NCh; i++) begin
      age_inc[i]  = (age_q[i] == mchw_pkg::AgeMax) ? age_q[i] : age_q[i] + 1'b1;
      reg_mask[i] = (owner_q[i] != '0);
      if (cfg_i.limit[i] > max_lim) begin
        max_lim = cfg_i.limit[i];
      end
      if (cfg_i.period[i] < min_per) begin
        min_per = cfg_i.period[i];
      end
    end
    for (int i = NCh - 1; i >= 0; i--) begin
      if (owner_q[i] == '0) begin
        unreg_any = 1'b1;
        unreg_idx = mchw_pkg::ChW'(i);
      end
      if (age_inc[i] > cfg_i.limit[i]) begin
        late_any = 1'b1;
        late_idx = mchw_pkg::ChW'(i);
      end
    end
  end

  always_comb begin
    ev = mchw_pkg::EvHalted;
    unique case (phase_q) inside
      mchw_pkg::PhReg, mchw_pkg::PhMon: begin
        if (item_i.mode) begin
          if (!ch_ok) begin
            ev = mchw_pkg::EvBadCh;
          end else if (imperson) begin
            ev = mchw_pkg::EvImperson;
          end else begin
            ev = mchw_pkg::EvBind;
          end
        end else if (phase_q == mchw_pkg::PhReg) begin
          if (win_inc >= max_lim) begin
            ev = unreg_any ? mchw_pkg::EvUnreg : mchw_pkg::EvWinPass;
          end else begin
            ev = mchw_pkg::EvTickReg;
          end
        end else if (samp_inc >= min_per) begin
          ev = late_any ? mchw_pkg::EvTimeout : mchw_pkg::EvSampPass;
        end else begin
          ev = mchw_pkg::EvTickMon;
        end
      end
      default: ev = mchw_pkg::EvHalted;
    endcase
  end

  always_comb begin
    case (ev) inside
      mchw_pkg::EvHalted, mchw_pkg::EvImperson, mchw_pkg::EvUnreg,
      mchw_pkg::EvTimeout: phase_d = mchw_pkg::PhHalt;
      mchw_pkg::EvWinPass: phase_d = mchw_pkg::PhMon;
      default:             phase_d = phase_q;
    endcase
  end

  always_comb begin
    res_o = '{status: mchw_pkg::StOk, kill_mask: '0, failed_channel: '0,
              monitoring: 1'b0};
    unique case (ev)
      mchw_pkg::EvHalted: res_o.status = mchw_pkg::StHalted;
      mchw_pkg::EvBadCh: begin
        res_o.status         = mchw_pkg::StBadChannel;
        res_o.failed_channel = item_i.channel;
        res_o.monitoring     = (phase_q == mchw_pkg::PhMon);
      end
      mchw_pkg::EvImperson: begin
        res_o.status         = mchw_pkg::StImperson;
        res_o.kill_mask      = reg_mask;
        res_o.failed_channel = item_i.channel;
      end
      mchw_pkg::EvBind:     res_o.monitoring = (phase_q == mchw_pkg::PhMon);
      mchw_pkg::EvTickReg:  res_o.monitoring = 1'b0;
      mchw_pkg::EvUnreg: begin
        res_o.status         = mchw_pkg::StUnreg;
        res_o.kill_mask      = reg_mask;
        res_o.failed_channel = unreg_idx;
      end
      mchw_pkg::EvTimeout: begin
        res_o.status         = mchw_pkg::StTimeout;
        res_o.kill_mask      = reg_mask;
        res_o.failed_channel = late_idx;
      end
      mchw_pkg::EvWinPass, mchw_pkg::EvTickMon, mchw_pkg::EvSampPass:
        res_o.monitoring = 1'b1;
      default: res_o.monitoring = 1'b0;
    endcase
  end

  always_comb begin
    owner_d = owner_q;
    age_d   = age_q;
    win_d   = win_q;
    samp_d  = samp_q;
    case (ev) inside
      mchw_pkg::EvBind: begin
        owner_d[sel] = item_i.sender_id;
        age_d[sel]   = '0;
      end
      mchw_pkg::EvTickReg, mchw_pkg::EvUnreg: begin
        age_d = age_inc;
        win_d = win_inc;
      end
      mchw_pkg::EvWinPass: begin
        age_d  = age_inc;
        win_d  = win_inc;
        samp_d = '0;
      end
      mchw_pkg::EvTickMon: begin
        age_d  = age_inc;
        samp_d = samp_inc;
      end
      mchw_pkg::EvSampPass, mchw_pkg::EvTimeout: begin
        age_d  = age_inc;
        samp_d = '0;
      end
      default: begin
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      phase_q <= mchw_pkg::PhReg;
      win_q   <= '0;
      samp_q  <= '0;
      owner_q <= '0;
      age_q   <= '0;
    end else if (advance_i) begin
      phase_q <= phase_d;
      win_q   <= win_d;
      samp_q  <= samp_d;
      owner_q <= owner_d;
      age_q   <= age_d;
    end
  end

endmodule

>>> rtl/core/multi_channel_heartbeat_watchdog_core.sv
// Top level of the heartbeat watchdog: input register, result register, handshakes.
// Depends on mchw_pkg, mchw_cfg, mchw_eval and the core defines header.
//
//   channel | signals                              | payload
//   --------+--------------------------------------+-------------------------
//   in      | in_valid_i  / in_ready_o             | in_item_i   (in_item_t)
//   out     | out_valid_o / out_ready_i            | out_item_o  (out_item_t)
//   cfg     | cfg_valid_i / cfg_ready_o            | cfg_index_i, cfg_wdata_i
//
// One item per cycle while out_ready_i is high; each item passes through the input register, then the result register.
// The item is evaluated as it moves from the input register into the result register.
// in_ready_o drops only while both registers hold an item and out_ready_i is low.
// Reset clears the valid flags and watchdog state and loads the default periods; no item needs to wait after reset.
// cfg_ready_o is always high; writes are registered in the period and limit registers.
`include "multi_channel_heartbeat_watchdog_core_defines.svh"

module multi_channel_heartbeat_watchdog_core (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  input  logic                          in_valid_i,
  output logic                          in_ready_o,
  input  mchw_pkg::in_item_t            in_item_i,
  output logic                          out_valid_o,
  input  logic                          out_ready_i,
  output mchw_pkg::out_item_t           out_item_o,
  input  logic                          cfg_valid_i,
  output logic                          cfg_ready_o,
  input  logic [mchw_pkg::RegIdxW-1:0]  cfg_index_i,
  input  logic [mchw_pkg::PeriodW-1:0]  cfg_wdata_i
);

  logic                in_valid_q;
  mchw_pkg::in_item_t  in_item_q;
  logic                out_valid_q;
  mchw_pkg::out_item_t out_item_q;
  logic                advance;
  mchw_pkg::cfg_t      cfg;
  mchw_pkg::out_item_t res;

  assign advance    = in_valid_q && (!out_valid_q || out_ready_i);
  assign in_ready_o = !in_valid_q || advance;

  mchw_cfg u_cfg (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cfg_valid_i (cfg_valid_i),
    .cfg_ready_o (cfg_ready_o),
    .cfg_index_i (cfg_index_i),
    .cfg_wdata_i (cfg_wdata_i),
    .cfg_o       (cfg)
  );

  mchw_eval u_eval (
    .clk_i     (clk_i),
    .rst_ni    (rst_ni),
    .advance_i (advance),
    .item_i    (in_item_q),
    .cfg_i     (cfg),
    .res_o     (res)
  );

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_valid_q  <= 1'b0;
      out_valid_q <= 1'b0;
    end else begin
      if (in_ready_o) begin
        in_valid_q <= in_valid_i;
      end
      if (advance) begin
        out_valid_q <= 1'b1;
      end else if (out_ready_i) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_valid_i && in_ready_o) begin
      in_item_q <= in_item_i;
    end
    if (advance) begin
      out_item_q <= res;
    end
  end

  assign out_valid_o = out_valid_q;
  assign out_item_o  = out_item_q;

  `MCHW_ASSERT_NOW(a_stall_only_when_full, !in_ready_o, in_valid_q && out_valid_q && !out_ready_i, "input stalled without a full pipeline")
  `MCHW_ASSERT_NEXT(a_fault_then_halted, out_valid_o && out_ready_i && (out_item_o.status == mchw_pkg::StImperson || out_item_o.status == mchw_pkg::StUnreg || out_item_o.status == mchw_pkg::StTimeout), !out_valid_o || out_item_o.status == mchw_pkg::StHalted, "item after a fault not reported as halted")
  `MCHW_ASSERT_NOW(a_halted_fields_zero, out_valid_o && out_item_o.status == mchw_pkg::StHalted, out_item_o.kill_mask == '0 && out_item_o.failed_channel == '0 && !out_item_o.monitoring, "halted result carries nonzero fields")
  `MCHW_ASSERT_NOW(a_mask_only_on_fault, out_valid_o && out_item_o.kill_mask != '0, out_item_o.status == mchw_pkg::StImperson || out_item_o.status == mchw_pkg::StUnreg || out_item_o.status == mchw_pkg::StTimeout, "kill mask set without a fault")

endmodule
